// ----- design/indexed_list_engine_defines.svh -----
// Assertion macros for the indexed list engine.
// Used by the top level only; depends on a clock named clk and a reset named rst_n.
`ifndef INDEXED_LIST_ENGINE_DEFINES_SVH
`define INDEXED_LIST_ENGINE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ILE_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("indexed_list_engine: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ILE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("indexed_list_engine: next-cycle check failed");

`endif

// ----- design/ile_pkg.sv -----
// Shared types and constants of the indexed list engine.
// No dependencies; used by the cell and the top level.
package ile_pkg;

    // Default number of list positions.
    localparam int CAPACITY_DEFAULT = 16;

    // Field widths.
    localparam int CMD_W   = 3;
    localparam int INDEX_W = 5;
    localparam int VALUE_W = 32;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic [CMD_W-1:0]          cmd_t;
    typedef logic [STAT_W-1:0]         status_t;

    // Command codes.
    localparam cmd_t CMD_INS_HEAD  = 3'd0;
    localparam cmd_t CMD_INS_TAIL  = 3'd1;
    localparam cmd_t CMD_INS_INDEX = 3'd2;
    localparam cmd_t CMD_READ      = 3'd3;
    localparam cmd_t CMD_DEL_HEAD  = 3'd4;
    localparam cmd_t CMD_DEL_TAIL  = 3'd5;
    localparam cmd_t CMD_DEL_INDEX = 3'd6;

    // Status codes.
    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_BAD_INDEX = 2'd1;
    localparam status_t ST_EMPTY     = 2'd2;
    localparam status_t ST_FULL      = 2'd3;

    // Cell operation broadcast along the row.
    typedef logic [1:0] op_t;
    localparam op_t OP_HOLD   = 2'd0;
    localparam op_t OP_INSERT = 2'd1;
    localparam op_t OP_DELETE = 2'd2;

    // Command word.
    typedef struct packed {
        cmd_t                command;
        logic [INDEX_W-1:0]  index;
        value_t              value;
    } req_word_t;

    // Result word.
    typedef struct packed {
        status_t             status;
        value_t              read_value;
        logic [COUNT_W-1:0]  count;
    } rsp_word_t;

endpackage

// ----- design/indexed_list_engine.sv -----
// Indexed list engine: ordered list of signed 32-bit words in a row of shifting cells.
// The result word appears with done in the cycle after the command is accepted.
// Throughput: one command per cycle; every cell shifts in parallel, so busy stays low.
// Reset clears the entry count and the done strobe; cell contents stay undefined
// and are never read before they are written.
// Depends on ile_pkg, ile_cell and indexed_list_engine_defines.svh.
`include "indexed_list_engine_defines.svh"

module indexed_list_engine #(
    parameter int CAPACITY = ile_pkg::CAPACITY_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  ile_pkg::req_word_t  request,
    output logic                done,
    output ile_pkg::rsp_word_t  result
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > ile_pkg::INDEX_W) ? CNT_W : ile_pkg::INDEX_W;
    localparam logic [CMP_W-1:0] CAP_EXT = CMP_W'(CAPACITY);

    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                done_reg;
    ile_pkg::rsp_word_t  result_reg;
    ile_pkg::rsp_word_t  result_next;

    logic                accept;
    logic [CMP_W-1:0]    count_ext;
    logic [CMP_W-1:0]    index_ext;
    logic                full;
    logic                empty;
    ile_pkg::op_t        op;
    logic [CMP_W-1:0]    pos;
    ile_pkg::value_t     read_data;
    ile_pkg::value_t     cell_data [CAPACITY];

    // Every command completes without stalling, so busy is tied low.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign count_ext = CMP_W'(count_reg);
    assign index_ext = CMP_W'(request.index);
    assign full      = (count_ext >= CAP_EXT);
    assign empty     = (count_reg == '0);

    // Read port: pick the cell that matches the index.
    always_comb
    begin
        read_data = '0;
        for (int k = 0; k < CAPACITY; k++)
        begin
            if (index_ext == CMP_W'(k))
            begin
                read_data = cell_data[k];
            end
        end
    end

    // Command decode: cell operation, new count and result word.
    always_comb
    begin
        op         = ile_pkg::OP_HOLD;
        pos        = '0;
        count_next = count_reg;
        result_next.status     = ile_pkg::ST_OK;
        result_next.read_value = '0;
        unique case (request.command)
            ile_pkg::CMD_INS_HEAD:
            begin
                if (full)
                begin
                    result_next.status = ile_pkg::ST_FULL;
                end
                else
                begin
                    op         = ile_pkg::OP_INSERT;
                    count_next = count_reg + 1'b1;
                end
            end
            ile_pkg::CMD_INS_TAIL:
            begin
                pos = count_ext;
                if (full)
                begin
                    result_next.status = ile_pkg::ST_FULL;
                end
                else
                begin
                    op         = ile_pkg::OP_INSERT;
                    count_next = count_reg + 1'b1;
                end
            end
            ile_pkg::CMD_INS_INDEX:
            begin
                pos = index_ext;
                if (index_ext > count_ext)
                begin
                    result_next.status = ile_pkg::ST_BAD_INDEX;
                end
                else if (full)
                begin
                    result_next.status = ile_pkg::ST_FULL;
                end
                else
                begin
                    op         = ile_pkg::OP_INSERT;
                    count_next = count_reg + 1'b1;
                end
            end
            ile_pkg::CMD_READ:
            begin
                if (index_ext >= count_ext)
                begin
                    result_next.status     = ile_pkg::ST_BAD_INDEX;
                    result_next.read_value = '1;
                end
                else
                begin
                    result_next.read_value = read_data;
                end
            end
            ile_pkg::CMD_DEL_HEAD:
            begin
                if (empty)
                begin
                    result_next.status = ile_pkg::ST_EMPTY;
                end
                else
                begin
                    op         = ile_pkg::OP_DELETE;
                    count_next = count_reg - 1'b1;
                end
            end
            ile_pkg::CMD_DEL_TAIL:
            begin
                pos = count_ext - 1'b1;
                if (empty)
                begin
                    result_next.status = ile_pkg::ST_EMPTY;
                end
                else
                begin
                    op         = ile_pkg::OP_DELETE;
                    count_next = count_reg - 1'b1;
                end
            end
            ile_pkg::CMD_DEL_INDEX:
            begin
                pos = index_ext;
                if (index_ext >= count_ext)
                begin
                    result_next.status = ile_pkg::ST_BAD_INDEX;
                end
                else
                begin
                    op         = ile_pkg::OP_DELETE;
                    count_next = count_reg - 1'b1;
                end
            end
            default:
            begin
                op = ile_pkg::OP_HOLD;
            end
        endcase
        result_next.count = ile_pkg::COUNT_W'(count_next);
        if (!accept)
        begin
            op         = ile_pkg::OP_HOLD;
            count_next = count_reg;
        end
    end

    // Row of cells; each one sees its two neighbors.
    for (genvar k = 0; k < CAPACITY; k++)
    begin : g_cell
        ile_pkg::value_t left_data;
        ile_pkg::value_t right_data;

        if (k == 0)
        begin : g_first
            assign left_data = '0;
        end
        else
        begin : g_inner_left
            assign left_data = cell_data[k-1];
        end

        if (k == CAPACITY - 1)
        begin : g_last
            assign right_data = '0;
        end
        else
        begin : g_inner_right
            assign right_data = cell_data[k+1];
        end

        ile_cell #(
            .POS   (k),
            .POS_W (CMP_W)
        ) u_cell (
            .clk        (clk),
            .op         (op),
            .pos        (pos),
            .value      (request.value),
            .left_data  (left_data),
            .right_data (right_data),
            .data       (cell_data[k])
        );
    end

    // Control state: entry count and the result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    // Result word register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // The count never passes the capacity.
    `ILE_ASSERT_SAME(a_count_bound, 1'b1, CMP_W'(count_reg) <= CAP_EXT)
    // Exactly one result word for each accepted command.
    `ILE_ASSERT_NEXT(a_done_follows, accept, done)
    `ILE_ASSERT_NEXT(a_no_spurious_done, !accept, !done)
    // The reported count matches the held count.
    `ILE_ASSERT_SAME(a_count_reported, done, result.count == ile_pkg::COUNT_W'(count_reg))
    // A flagged command leaves the list length unchanged.
    `ILE_ASSERT_SAME(a_error_holds, done && (result.status != ile_pkg::ST_OK),
        $stable(count_reg))

endmodule

// ----- design/ile_cell.sv -----
// One list position of the indexed list engine.
// Depends on ile_pkg; the top level chains CAPACITY of these cells.
module ile_cell #(
    parameter int POS   = 0,
    parameter int POS_W = 5
) (
    input  logic                clk,
    input  ile_pkg::op_t        op,
    input  logic [POS_W-1:0]    pos,
    input  ile_pkg::value_t     value,
    input  ile_pkg::value_t     left_data,
    input  ile_pkg::value_t     right_data,
    output ile_pkg::value_t     data
);

    localparam logic [POS_W-1:0] MY_POS = POS_W'(POS);

    ile_pkg::value_t data_reg;
    ile_pkg::value_t data_next;

    // Insert moves entries above the gap up one place; delete moves them down.
    always_comb
    begin
        data_next = data_reg;
        unique case (op)
            ile_pkg::OP_INSERT:
            begin
                if (MY_POS > pos)
                begin
                    data_next = left_data;
                end
                else if (MY_POS == pos)
                begin
                    data_next = value;
                end
            end
            ile_pkg::OP_DELETE:
            begin
                if (MY_POS >= pos)
                begin
                    data_next = right_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    // Entry storage; contents are undefined until written.
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ----- test/tb_indexed_list_engine.sv -----
// Testbench for the indexed list engine: directed list operations, then random sweeps.
// Depends on ile_pkg and the indexed_list_engine top level; self-checking against
// a behavioral list predictor.
module tb_indexed_list_engine;

    import ile_pkg::*;

    localparam int   DEPTH       = CAPACITY_DEFAULT;
    localparam int   RANDOM_WORDS = 1600;
    localparam int   CYCLE_LIMIT  = 200000;
    localparam cmd_t CMD_UNUSED   = 3'd7;

    typedef enum int {SWEEP_FILL, SWEEP_DRAIN, SWEEP_MIXED, SWEEP_READS} sweep_t;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    req_word_t  request;
    logic       done;
    rsp_word_t  result;

    // Predictor state: the list as the block should hold it.
    value_t     list_mem [DEPTH];
    int         list_len;

    rsp_word_t  expected_results [$];
    int         error_count;
    int         words_sent;
    int         burst_left;
    int         cycle_count;

    indexed_list_engine #(.CAPACITY(DEPTH)) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    // Clock with a period of 4.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Open a slot at pos, moving later entries up one place.
    function automatic void open_slot(input int pos, input value_t v);
        for (int k = list_len; k > pos; k--)
        begin
            list_mem[k] = list_mem[k-1];
        end
        list_mem[pos] = v;
        list_len++;
    endfunction

    // Remove the entry at pos, moving later entries down one place.
    function automatic void close_slot(input int pos);
        for (int k = pos; k + 1 < list_len; k++)
        begin
            list_mem[k] = list_mem[k+1];
        end
        list_len--;
    endfunction

    // Apply one command word to the predicted list and return the expected result word.
    function automatic rsp_word_t apply_list_command(input req_word_t w);
        rsp_word_t r;
        logic      full;
        int        idx;
        r.status     = ST_OK;
        r.read_value = '0;
        full         = (list_len >= DEPTH);
        idx          = int'(w.index);
        case (w.command)
            CMD_INS_HEAD:
                if (full) r.status = ST_FULL;
                else open_slot(0, w.value);
            CMD_INS_TAIL:
                if (full) r.status = ST_FULL;
                else open_slot(list_len, w.value);
            CMD_INS_INDEX:
                if (idx > list_len) r.status = ST_BAD_INDEX;
                else if (full) r.status = ST_FULL;
                else open_slot(idx, w.value);
            CMD_READ:
                if (idx >= list_len)
                begin
                    r.status     = ST_BAD_INDEX;
                    r.read_value = -1;
                end
                else
                begin
                    r.read_value = list_mem[idx];
                end
            CMD_DEL_HEAD:
                if (list_len == 0) r.status = ST_EMPTY;
                else close_slot(0);
            CMD_DEL_TAIL:
                if (list_len == 0) r.status = ST_EMPTY;
                else close_slot(list_len - 1);
            CMD_DEL_INDEX:
                if (idx >= list_len) r.status = ST_BAD_INDEX;
                else close_slot(idx);
            default:
                ;
        endcase
        r.count = COUNT_W'(list_len);
        return r;
    endfunction

    // Send one command word. Called right after a falling edge; leaves start high so the
    // next word can follow back to back. Most bursts end in random gaps with start low.
    task automatic send_word(input cmd_t c, input logic [INDEX_W-1:0] idx, input value_t v);
        req_word_t w;
        int        gap;
        w.command = c;
        w.index   = idx;
        w.value   = v;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 30);
            if ($urandom_range(0, 3) != 0)
            begin
                gap = $urandom_range(1, 5);
                start   <= 1'b0;
                request <= req_word_t'($bits(req_word_t)'({$urandom, $urandom}));
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        start   <= 1'b1;
        request <= w;
        do @(posedge clk); while (busy);
        expected_results.push_back(apply_list_command(w));
        words_sent++;
        @(negedge clk);
    endtask

    // Hold the sender off until every expected result word has come back.
    task automatic wait_for_results();
        start <= 1'b0;
        do @(negedge clk); while (expected_results.size() != 0);
    endtask

    // Commands on an empty list: reads and deletes fail, and so do bad inserts.
    task automatic test_empty_list();
        send_word(CMD_READ, 5'd0, 32'sd0);
        send_word(CMD_DEL_HEAD, 5'd0, 32'sd0);
        send_word(CMD_DEL_TAIL, 5'd0, 32'sd0);
        send_word(CMD_DEL_INDEX, 5'd0, 32'sd0);
        send_word(CMD_INS_INDEX, 5'd1, 32'sd7);
        send_word(CMD_UNUSED, 5'd31, -32'sd1);
    endtask

    // Fill the list with every insert kind, extreme values first.
    task automatic test_fill_to_capacity();
        send_word(CMD_INS_HEAD, 5'd0, 32'sh7fffffff);
        send_word(CMD_INS_TAIL, 5'd0, 32'sh80000000);
        send_word(CMD_INS_INDEX, 5'd1, -32'sd1);
        send_word(CMD_INS_INDEX, 5'd3, 32'sd0);
        for (int k = 4; k < DEPTH; k++)
        begin
            case (k % 3)
                0: send_word(CMD_INS_HEAD, 5'($urandom), $urandom);
                1: send_word(CMD_INS_TAIL, 5'($urandom), $urandom);
                default: send_word(CMD_INS_INDEX, 5'($urandom_range(0, k)), $urandom);
            endcase
        end
    endtask

    // A full list refuses inserts; the index check comes before the full check.
    // Then reads and deletes at the bounds.
    task automatic test_full_list_and_bounds();
        send_word(CMD_INS_HEAD, 5'd0, 32'sd1);
        send_word(CMD_INS_TAIL, 5'd0, 32'sd2);
        send_word(CMD_INS_INDEX, 5'd5, 32'sd3);
        send_word(CMD_INS_INDEX, 5'd17, 32'sd4);
        send_word(CMD_READ, 5'd15, 32'sd0);
        send_word(CMD_READ, 5'd16, 32'sd0);
        send_word(CMD_READ, 5'd31, 32'sd0);
        send_word(CMD_DEL_INDEX, 5'd16, 32'sd0);
        send_word(CMD_DEL_INDEX, 5'd0, 32'sd0);
        send_word(CMD_DEL_TAIL, 5'd0, 32'sd0);
        send_word(CMD_DEL_HEAD, 5'd0, 32'sd0);
        wait_for_results();
    endtask

    // Random sweeps that fill, drain, mix or mostly read the list, with mostly valid indexes.
    task automatic test_random_sweeps();
        sweep_t            sweep;
        int                run_len;
        int                p_ins;
        int                p_del;
        int                p_read;
        int                roll;
        int                rounds;
        cmd_t              c;
        logic [INDEX_W-1:0] idx;
        value_t            v;
        rounds = 0;
        while (words_sent < RANDOM_WORDS + 40)
        begin
            sweep   = sweep_t'($urandom_range(0, 3));
            run_len = $urandom_range(8, 40);
            case (sweep)
                SWEEP_FILL:
                begin
                    p_ins  = 70;
                    p_del  = 12;
                    p_read = 15;
                end
                SWEEP_DRAIN:
                begin
                    p_ins  = 12;
                    p_del  = 70;
                    p_read = 15;
                end
                SWEEP_READS:
                begin
                    p_ins  = 15;
                    p_del  = 15;
                    p_read = 67;
                end
                default:
                begin
                    p_ins  = 40;
                    p_del  = 40;
                    p_read = 17;
                end
            endcase
            repeat (run_len)
            begin
                roll = $urandom_range(0, 99);
                if (roll < p_ins)
                begin
                    case ($urandom_range(0, 2))
                        0: c = CMD_INS_HEAD;
                        1: c = CMD_INS_TAIL;
                        default: c = CMD_INS_INDEX;
                    endcase
                    idx = 5'($urandom_range(0, list_len));
                end
                else if (roll < p_ins + p_del)
                begin
                    case ($urandom_range(0, 2))
                        0: c = CMD_DEL_HEAD;
                        1: c = CMD_DEL_TAIL;
                        default: c = CMD_DEL_INDEX;
                    endcase
                    idx = (list_len > 0) ? 5'($urandom_range(0, list_len - 1)) : 5'($urandom);
                end
                else if (roll < p_ins + p_del + p_read)
                begin
                    c   = CMD_READ;
                    idx = (list_len > 0) ? 5'($urandom_range(0, list_len - 1)) : 5'($urandom);
                end
                else
                begin
                    c   = CMD_UNUSED;
                    idx = 5'($urandom);
                end
                // Some indexes anywhere in the field, mostly out of range.
                if ($urandom_range(0, 9) >= 8)
                begin
                    idx = 5'($urandom);
                end
                v = $urandom;
                if ($urandom_range(0, 7) == 0)
                begin
                    case ($urandom_range(0, 3))
                        0: v = 32'sh7fffffff;
                        1: v = 32'sh80000000;
                        2: v = 32'sd0;
                        default: v = -32'sd1;
                    endcase
                end
                send_word(c, idx, v);
            end
            rounds++;
            if (rounds % 20 == 0)
            begin
                wait_for_results();
            end
        end
    endtask

    // Compare each result word with the oldest expectation.
    always @(posedge clk)
    begin
        rsp_word_t expd;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result word with no expectation waiting");
                error_count++;
            end
            else
            begin
                expd = expected_results.pop_front();
                if (result.status !== expd.status)
                begin
                    $error("status: expected %0d, got %0d", expd.status, result.status);
                    error_count++;
                end
                if (result.read_value !== expd.read_value)
                begin
                    $error("read_value: expected %0d, got %0d",
                           expd.read_value, result.read_value);
                    error_count++;
                end
                if (result.count !== expd.count)
                begin
                    $error("count: expected %0d, got %0d", expd.count, result.count);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        request     = '0;
        list_len    = 0;
        error_count = 0;
        words_sent  = 0;
        burst_left  = 0;
        cycle_count = 0;
        for (int k = 0; k < DEPTH; k++)
        begin
            list_mem[k] = '0;
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_list();
        test_fill_to_capacity();
        test_full_list_and_bounds();
        test_random_sweeps();

        // Let the last result words come back before deciding.
        wait_for_results();
        repeat (4) @(negedge clk);
        if (error_count == 0 && expected_results.size() == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+design
design/ile_pkg.sv
design/ile_cell.sv
design/indexed_list_engine.sv
test/tb_indexed_list_engine.sv
